// ===== sv/ps2m_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2m_pkg
// Shared types and constants for the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package ps2m_pkg;

    // Position of the next byte within a three-byte packet.
    localparam logic [1:0] POS_HDR = 2'd0;
    localparam logic [1:0] POS_X   = 2'd1;
    localparam logic [1:0] POS_Y   = 2'd2;

    // Header bit that must be set in a well-aligned packet.
    localparam int SYNC_BIT    = 3;
    localparam int NUM_BUTTONS = 3;

    // Event kinds on the output channel.
    localparam logic [1:0] EV_MOVE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    // The events caused by one byte, awaiting delivery.
    typedef struct packed {
        logic                   move;
        logic [NUM_BUTTONS-1:0] chg;
        logic [NUM_BUTTONS-1:0] newb;
        logic signed [7:0]      dx;
        logic signed [8:0]      dy;
    } evset_t;

endpackage

// ===== sv/ps2m_asm.sv =====
// ----------------------------------------------------------------------------
// ps2m_asm
// Packet assembler: holds the packet state and works out the set of events
// that the incoming byte causes.
// ----------------------------------------------------------------------------
module ps2m_asm
    import ps2m_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    output evset_t     set
);

    logic [1:0]             pos_reg, pos_next;
    logic [7:0]             hdr_reg, hdr_next;
    logic [7:0]             x_reg, x_next;
    logic [NUM_BUTTONS-1:0] btn_reg, btn_next;

    always_comb
    begin
        pos_next = pos_reg;
        hdr_next = hdr_reg;
        x_next   = x_reg;
        btn_next = btn_reg;
        set      = '0;
        case (pos_reg)
            POS_X:
            begin
                x_next   = data_byte;
                pos_next = POS_Y;
            end
            POS_Y:
            begin
                pos_next = POS_HDR;
                if (hdr_reg[SYNC_BIT])
                begin
                    set.move = (x_reg != 8'd0) || (data_byte != 8'd0);
                    if (set.move)
                    begin
                        set.dx = x_reg;
                        // Negate the signed Y movement into nine bits.
                        set.dy = 9'sd0 - $signed({data_byte[7], data_byte});
                    end
                    set.chg  = btn_reg ^ hdr_reg[NUM_BUTTONS-1:0];
                    set.newb = hdr_reg[NUM_BUTTONS-1:0];
                    btn_next = hdr_reg[NUM_BUTTONS-1:0];
                end
            end
            default:
            begin
                hdr_next = data_byte;
                pos_next = POS_X;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HDR;
            hdr_reg <= '0;
            x_reg   <= '0;
            btn_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            hdr_reg <= hdr_next;
            x_reg   <= x_next;
            btn_reg <= btn_next;
        end
    end

endmodule

// ===== sv/ps2m_emit.sv =====
// ----------------------------------------------------------------------------
// ps2m_emit
// Event emitter: holds the pending event set and delivers one event per
// cycle through the output register while the receiver is ready.
// ----------------------------------------------------------------------------
module ps2m_emit
    import ps2m_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  evset_t            set,
    output logic              pend_any,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        event_kind,
    output logic signed [7:0] delta_x,
    output logic signed [8:0] delta_y,
    output logic [1:0]        button_number,
    output logic              last_event
);

    evset_t            pend_reg, pend_next;
    evset_t            src;
    logic              valid_reg, valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic signed [7:0] dx_reg, dx_next;
    logic signed [8:0] dy_reg, dy_next;
    logic [1:0]        btn_reg, btn_next;
    logic              last_reg, last_next;
    logic              take;

    assign pend_any = pend_reg.move || (pend_reg.chg != '0);
    assign take     = !valid_reg || out_ready;

    // A new set is only loaded while nothing is pending, so the first event
    // of a freshly loaded set can go straight to the output register.
    assign src = load ? set : pend_reg;

    always_comb
    begin
        pend_next  = src;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        btn_next   = btn_reg;
        last_next  = last_reg;
        if (take)
        begin
            valid_next = src.move || (src.chg != '0);
            dx_next    = '0;
            dy_next    = '0;
            btn_next   = '0;
            kind_next  = EV_MOVE;
            if (src.move)
            begin
                dx_next        = src.dx;
                dy_next        = src.dy;
                pend_next.move = 1'b0;
            end
            else if (src.chg[0])
            begin
                kind_next        = src.newb[0] ? EV_PRESS : EV_RELEASE;
                btn_next         = 2'd1;
                pend_next.chg[0] = 1'b0;
            end
            else if (src.chg[1])
            begin
                kind_next        = src.newb[1] ? EV_PRESS : EV_RELEASE;
                btn_next         = 2'd2;
                pend_next.chg[1] = 1'b0;
            end
            else if (src.chg[2])
            begin
                kind_next        = src.newb[2] ? EV_PRESS : EV_RELEASE;
                btn_next         = 2'd3;
                pend_next.chg[2] = 1'b0;
            end
            last_next = !(pend_next.move || (pend_next.chg != '0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        btn_reg  <= btn_next;
        last_reg <= last_next;
    end

    assign out_valid     = valid_reg;
    assign event_kind    = kind_reg;
    assign delta_x       = dx_reg;
    assign delta_y       = dy_reg;
    assign button_number = btn_reg;
    assign last_event    = last_reg;

endmodule

// ===== sv/ps2_mouse_packet_decoder_top.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_top
// Assembles PS/2 mouse bytes into three-byte packets and emits move and
// button events.
// ----------------------------------------------------------------------------
// Bytes received from the mouse enter as requests on the input channel
// (in_valid, in_ready, data_byte). Every third byte completes a packet. If
// the header byte has its sync bit set, the packet yields a move event when
// either movement is nonzero, then a press or release event for each button
// whose state changed, in button order. The last event of a byte is marked
// by last_event. A packet with a clear sync bit is dropped silently.
// Events leave as requests on the output channel (out_valid, out_ready and
// the event fields).
// The first event of a packet is written into the output register at the
// edge that accepts the third byte, so it is offered in the very next cycle
// when the output register is free. Events leave at one per cycle while the
// receiver is ready. The pending event register is what paces the input: a
// new byte is taken only once all events of the previous one have moved out
// of it. Reset clears the packet position, the stored bytes, the button
// states and any pending events. When the receiver stalls, the current event
// holds on the output and the remaining events wait in the pending register.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder_top
    import ps2m_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        event_kind,
    output logic signed [7:0] delta_x,
    output logic signed [8:0] delta_y,
    output logic [1:0]        button_number,
    output logic              last_event
);

    evset_t set;
    logic   pend_any;
    logic   accept;

    // The byte is taken only when no events of the previous byte wait.
    assign in_ready = !pend_any;
    assign accept   = in_valid && in_ready;

    ps2m_asm u_asm (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .set       (set)
    );

    ps2m_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .set           (set),
        .pend_any      (pend_any),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .delta_x       (delta_x),
        .delta_y       (delta_y),
        .button_number (button_number),
        .last_event    (last_event)
    );

`ifndef NO_ASSERTIONS
    // A move event carries no button number.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == EV_MOVE) |-> button_number == 2'd0)
        else $error("move event with a button number");

    // A button event carries no movement and names a real button.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind != EV_MOVE)
        |-> (delta_x == 8'sd0) && (delta_y == 9'sd0) && (button_number != 2'd0))
        else $error("button event with movement or no button");

    // While further events of the same byte wait, no new byte is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_event |-> !in_ready)
        else $error("input ready while events of a byte still wait");
`endif

endmodule
